// ===== rtl/core/dual_channel_pulse_tachometer_core_defines.svh =====
// Assertion macros for the tachometer core.
`ifndef DUAL_CHANNEL_PULSE_TACHOMETER_CORE_DEFINES_SVH
`define DUAL_CHANNEL_PULSE_TACHOMETER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define DCPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tachometer core: same-cycle check failed");

// Next-cycle implication, ignored while reset is held.
`define DCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tachometer core: next-cycle check failed");

`endif

// ===== rtl/core/dcpt_pkg.sv =====
package dcpt_pkg;

  // Fixed field widths
  localparam int TIME_W  = 32;
  localparam int SUM_W   = 32;
  localparam int FREQ_W  = 32;
  localparam int RPM_W   = 32;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WIN_W   = 16;
  localparam int THR_W   = 16;
  localparam int PPR_W   = 8;

  localparam int FREQ_FRAC_BITS    = 8;
  localparam int PULSE_COUNT_WIDTH = 16;

  // Numerator widths for the shared divider
  localparam int US_PER_S    = 1000000;
  localparam int US_W        = 20;
  localparam int RPM_PER_HZ  = 60;
  localparam int FREQ_NUM_W  = PULSE_COUNT_WIDTH + US_W + FREQ_FRAC_BITS;
  localparam int RPM_NUM_W   = FREQ_W + 6;
  localparam int DIV_NUM_W   = (FREQ_NUM_W > RPM_NUM_W) ? FREQ_NUM_W : RPM_NUM_W;
  localparam int DIV_W       = 32;
  localparam int HI_W        = DIV_NUM_W - DIV_W;
  localparam int CMP_W       = (HI_W > DIV_W) ? HI_W : DIV_W;
  localparam int DIV_STEPS   = DIV_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Event kinds
  localparam logic [MODE_W-1:0] MODE_PORT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STBD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POLL = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PPR       = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_MS_RST = 16'd1000;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd77;
  localparam logic [PPR_W-1:0] PPR_RST       = 8'd4;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] hi;
    logic [DIV_W-1:0] lo;
    logic [DIV_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/dcpt_if.sv =====
interface dcpt_in_if;
  import dcpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TIME_W-1:0] time_us;
  logic [TIME_W-1:0] time_ms;
  modport source (output valid, mode, time_us, time_ms, input ready);
  modport sink   (input valid, mode, time_us, time_ms, output ready);
endinterface

interface dcpt_out_if;
  import dcpt_pkg::*;
  logic             valid;
  logic             ready;
  logic             window_closed;
  logic             changed;
  logic [RPM_W-1:0] port_rpm;
  logic [RPM_W-1:0] starboard_rpm;
  modport source (output valid, window_closed, changed, port_rpm, starboard_rpm,
                  input ready);
  modport sink   (input valid, window_closed, changed, port_rpm, starboard_rpm,
                  output ready);
endinterface

interface dcpt_cfg_if;
  import dcpt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dcpt_acc.sv =====
module dcpt_acc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 hit,
  input  logic [dcpt_pkg::TIME_W-1:0]          t_us,
  input  logic                                 clear,
  output logic [dcpt_pkg::SUM_W-1:0]           sum,
  output logic [dcpt_pkg::PULSE_COUNT_WIDTH-1:0] cnt
);
  import dcpt_pkg::*;

  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [PULSE_COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]            last_r, last_nxt;
  logic [TIME_W-1:0]            gap;
  logic [SUM_W:0]               sum_wide;

  assign gap      = t_us - last_r;
  assign sum_wide = {1'b0, sum_r} + {1'b0, gap};

  always_comb begin
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (clear) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (hit) begin
      // saturate both the duration and the pulse count
      sum_nxt  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      last_nxt = t_us;
      if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      last_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
  end

  assign sum = sum_r;
  assign cnt = cnt_r;

endmodule

// ===== rtl/core/dcpt_div.sv =====
module dcpt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dcpt_pkg::div_req_t req,
  output dcpt_pkg::div_rsp_t rsp
);
  import dcpt_pkg::*;

  // Restoring divider, one quotient bit a cycle. The high part of the
  // dividend must already be below the divisor.
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.hi;
      quo_nxt  = req.lo;
      dvs_nxt  = req.dvs;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// ===== rtl/core/dual_channel_pulse_tachometer_core.sv =====
// Two-channel engine tachometer (port and starboard). An edge item adds the
// microsecond gap since that channel's previous edge to its duration and
// counts a pulse; the block is ready again at once for the next item.
// A poll item closes the window once window_ms has elapsed, works out each
// channel's frequency (pulses * 1e6 / duration, 8 fractional bits,
// truncating, zero for an idle channel), clears both accumulators and
// replaces the held frequencies together if either moved by more than
// change_threshold. Every poll returns one result item with the rpm of the
// held frequencies (freq * 60 / pulses_per_rev, saturating). All quotients
// come from one shared restoring divider giving one bit a cycle: a poll
// inside the window runs two rpm divisions, a poll that closes it four
// (two frequency and two rpm divisions), fewer when a channel is idle or
// saturates. A finished result sits in the output register while the next
// item is taken.
`include "dual_channel_pulse_tachometer_core_defines.svh"

module dual_channel_pulse_tachometer_core (
  input  logic              clk,
  input  logic              rst_n,
  dcpt_in_if.sink           in_if,
  dcpt_out_if.source        out_if,
  dcpt_cfg_if.sink          cfg_if
);
  import dcpt_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_STORE  = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Divisions, in the order they are run
  localparam logic [1:0] JOB_PF = 2'd0;
  localparam logic [1:0] JOB_SF = 2'd1;
  localparam logic [1:0] JOB_PR = 2'd2;
  localparam logic [1:0] JOB_SR = 2'd3;

  // Configuration
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [PPR_W-1:0] ppr_r, ppr_nxt;

  // Sequencer and held state
  logic [2:0]        state_r, state_nxt;
  logic [1:0]        job_r, job_nxt;
  logic [TIME_W-1:0] wstart_r, wstart_nxt;
  logic [FREQ_W-1:0] held_p_r, held_p_nxt;
  logic [FREQ_W-1:0] held_s_r, held_s_nxt;
  logic              closed_r, closed_nxt;
  logic              chg_r, chg_nxt;

  // Working payload
  logic [DIV_NUM_W-1:0] n_r, n_nxt;
  logic [DIV_W-1:0]     d_r, d_nxt;
  logic                 zero_r, zero_nxt;
  logic [DIV_W-1:0]     res_r, res_nxt;
  logic [FREQ_W-1:0]    pf_r, pf_nxt;
  logic [FREQ_W-1:0]    sf_r, sf_nxt;
  logic [RPM_W-1:0]     prpm_r, prpm_nxt;
  logic [RPM_W-1:0]     srpm_r, srpm_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_closed_r, out_closed_nxt;
  logic             out_chg_r, out_chg_nxt;
  logic [RPM_W-1:0] out_prpm_r, out_prpm_nxt;
  logic [RPM_W-1:0] out_srpm_r, out_srpm_nxt;

  // Accumulator hook-up
  logic                         in_acc;
  logic                         acc_clear;
  logic [SUM_W-1:0]             p_sum, s_sum;
  logic [PULSE_COUNT_WIDTH-1:0] p_cnt, s_cnt;

  // Operand selection
  logic [PULSE_COUNT_WIDTH-1:0] sel_cnt;
  logic [SUM_W-1:0]             sel_sum;
  logic [FREQ_W-1:0]            sel_freq;
  logic [FREQ_NUM_W-1:0]        freq_num;
  logic [RPM_NUM_W-1:0]         rpm_num;
  logic [DIV_W-1:0]             ppr_eff;
  logic [HI_W-1:0]              n_hi;
  logic                         sat;
  logic [TIME_W-1:0]            elapsed;
  logic [FREQ_W-1:0]            dp, ds;
  logic                         moved;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc        = in_if.valid && in_if.ready;
  assign in_if.ready   = (state_r == S_IDLE);
  assign cfg_if.ready  = 1'b1;
  assign acc_clear     = (state_r == S_DECIDE);

  dcpt_acc u_acc_port (
    .clk   (clk),
    .rst_n (rst_n),
    .hit   (in_acc && (in_if.mode == MODE_PORT)),
    .t_us  (in_if.time_us),
    .clear (acc_clear),
    .sum   (p_sum),
    .cnt   (p_cnt)
  );

  dcpt_acc u_acc_stbd (
    .clk   (clk),
    .rst_n (rst_n),
    .hit   (in_acc && (in_if.mode == MODE_STBD)),
    .t_us  (in_if.time_us),
    .clear (acc_clear),
    .sum   (s_sum),
    .cnt   (s_cnt)
  );

  dcpt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Pick the channel for the current job; one constant multiply per job
  assign sel_cnt  = (job_r == JOB_PF) ? p_cnt : s_cnt;
  assign sel_sum  = (job_r == JOB_PF) ? p_sum : s_sum;
  assign sel_freq = (job_r == JOB_PR) ? held_p_r : held_s_r;
  assign freq_num = FREQ_NUM_W'(FREQ_NUM_W'(sel_cnt) * FREQ_NUM_W'(US_PER_S))
                    << FREQ_FRAC_BITS;
  assign rpm_num  = RPM_NUM_W'(RPM_NUM_W'(sel_freq) * RPM_NUM_W'(RPM_PER_HZ));
  assign ppr_eff  = (ppr_r == '0) ? DIV_W'(1) : DIV_W'(ppr_r);

  // Quotient overflows 32 bits exactly when the high part reaches the divisor
  assign n_hi = n_r[DIV_NUM_W-1:DIV_W];
  assign sat  = CMP_W'(n_hi) >= CMP_W'(d_r);

  assign elapsed = in_if.time_ms - wstart_r;

  assign dp    = (held_p_r > pf_r) ? (held_p_r - pf_r) : (pf_r - held_p_r);
  assign ds    = (held_s_r > sf_r) ? (held_s_r - sf_r) : (sf_r - held_s_r);
  assign moved = (dp > FREQ_W'(thr_r)) || (ds > FREQ_W'(thr_r));

  assign div_req.start = (state_r == S_CHECK) && !zero_r && !sat;
  assign div_req.hi    = DIV_W'(n_hi);
  assign div_req.lo    = n_r[DIV_W-1:0];
  assign div_req.dvs   = d_r;

  // Configuration writes
  always_comb begin
    win_nxt = win_r;
    thr_nxt = thr_r;
    ppr_nxt = ppr_r;
    if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        REG_WINDOW_MS: win_nxt = cfg_if.data[WIN_W-1:0];
        REG_THRESHOLD: thr_nxt = cfg_if.data[THR_W-1:0];
        REG_PPR:       ppr_nxt = cfg_if.data[PPR_W-1:0];
        default:       ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    wstart_nxt = wstart_r;
    held_p_nxt = held_p_r;
    held_s_nxt = held_s_r;
    closed_nxt = closed_r;
    chg_nxt    = chg_r;
    n_nxt      = n_r;
    d_nxt      = d_r;
    zero_nxt   = zero_r;
    res_nxt    = res_r;
    pf_nxt     = pf_r;
    sf_nxt     = sf_r;
    prpm_nxt   = prpm_r;
    srpm_nxt   = srpm_r;

    out_valid_nxt  = out_valid_r;
    out_closed_nxt = out_closed_r;
    out_chg_nxt    = out_chg_r;
    out_prpm_nxt   = out_prpm_r;
    out_srpm_nxt   = out_srpm_r;

    // drop the result once it has been taken
    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // edges go straight to the accumulators; unused mode is dropped
        if (in_acc && (in_if.mode == MODE_POLL)) begin
          chg_nxt   = 1'b0;
          state_nxt = S_LOAD;
          if (elapsed >= TIME_W'(win_r)) begin
            closed_nxt = 1'b1;
            wstart_nxt = in_if.time_ms;
            job_nxt    = JOB_PF;
          end else begin
            closed_nxt = 1'b0;
            job_nxt    = JOB_PR;
          end
        end
      end
      S_LOAD: begin
        if ((job_r == JOB_PF) || (job_r == JOB_SF)) begin
          n_nxt    = DIV_NUM_W'(freq_num);
          d_nxt    = DIV_W'(sel_sum);
          zero_nxt = (sel_cnt == '0) || (sel_sum == '0);
        end else begin
          n_nxt    = DIV_NUM_W'(rpm_num);
          d_nxt    = ppr_eff;
          zero_nxt = 1'b0;
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (zero_r) begin
          res_nxt   = '0;
          state_nxt = S_STORE;
        end else if (sat) begin
          res_nxt   = '1;
          state_nxt = S_STORE;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quot;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        unique case (job_r)
          JOB_PF: begin
            pf_nxt    = res_r;
            job_nxt   = JOB_SF;
            state_nxt = S_LOAD;
          end
          JOB_SF: begin
            sf_nxt    = res_r;
            state_nxt = S_DECIDE;
          end
          JOB_PR: begin
            prpm_nxt  = res_r;
            job_nxt   = JOB_SR;
            state_nxt = S_LOAD;
          end
          default: begin
            srpm_nxt  = res_r;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DECIDE: begin
        // accumulators clear here; held pair replaced together
        if (moved) begin
          chg_nxt    = 1'b1;
          held_p_nxt = pf_r;
          held_s_nxt = sf_r;
        end
        job_nxt   = JOB_PR;
        state_nxt = S_LOAD;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_closed_nxt = closed_r;
          out_chg_nxt    = chg_r;
          out_prpm_nxt   = prpm_r;
          out_srpm_nxt   = srpm_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WINDOW_MS_RST;
      thr_r       <= THRESHOLD_RST;
      ppr_r       <= PPR_RST;
      state_r     <= S_IDLE;
      job_r       <= JOB_PF;
      wstart_r    <= '0;
      held_p_r    <= '0;
      held_s_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      thr_r       <= thr_nxt;
      ppr_r       <= ppr_nxt;
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      wstart_r    <= wstart_nxt;
      held_p_r    <= held_p_nxt;
      held_s_r    <= held_s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    closed_r     <= closed_nxt;
    chg_r        <= chg_nxt;
    n_r          <= n_nxt;
    d_r          <= d_nxt;
    zero_r       <= zero_nxt;
    res_r        <= res_nxt;
    pf_r         <= pf_nxt;
    sf_r         <= sf_nxt;
    prpm_r       <= prpm_nxt;
    srpm_r       <= srpm_nxt;
    out_closed_r <= out_closed_nxt;
    out_chg_r    <= out_chg_nxt;
    out_prpm_r   <= out_prpm_nxt;
    out_srpm_r   <= out_srpm_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.window_closed = out_closed_r;
  assign out_if.changed       = out_chg_r;
  assign out_if.port_rpm      = out_prpm_r;
  assign out_if.starboard_rpm = out_srpm_r;

  // Divider only reports back while the sequencer waits for it
  `DCPT_ASSERT_NOW(a_div_done_in_run, clk, rst_n, div_rsp.done, state_r == S_RUN)
  // A change can only be reported by a poll that closed the window
  `DCPT_ASSERT_NOW(a_chg_needs_close, clk, rst_n, out_valid_r && out_chg_r, out_closed_r)
  // A poll starts the sequencer on the next cycle
  `DCPT_ASSERT_NEXT(a_poll_starts, clk, rst_n, in_acc && (in_if.mode == MODE_POLL),
                    state_r == S_LOAD)
  // A finished poll lands in the output register once it is free
  `DCPT_ASSERT_NEXT(a_done_fills_out, clk, rst_n, (state_r == S_DONE) && !out_valid_r,
                    out_valid_r && (state_r == S_IDLE))

endmodule
